FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, gated by reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/poap_pkg.sv
// ----------------------------------------------------------------------------
// poap_pkg
// Widths and request types for the point onto axis projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package poap_pkg;

	localparam int COORD_W    = 24;
	localparam int AXIS_W     = 16;
	localparam int LEN_W      = 32;
	localparam int RES_W      = 32;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int PROD_W     = DIFF_W + AXIS_W;
	localparam int DOT_W      = PROD_W + 2;
	localparam int NUM_W      = DOT_W + AXIS_W;
	localparam int MAG_W      = 57;
	localparam int DIV_STAGES = MAG_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic signed [AXIS_W-1:0]  axis_x;
		logic signed [AXIS_W-1:0]  axis_y;
		logic signed [AXIS_W-1:0]  axis_z;
		logic        [LEN_W-1:0]   axis_length_sq;
	} query_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_x;
		logic signed [RES_W-1:0] result_y;
		logic signed [RES_W-1:0] result_z;
		logic                    projected;
	} answer_t;

	typedef struct packed {
		logic signed [RES_W-1:0] res;
		logic                    proj;
	} lane_out_t;

endpackage
`default_nettype wire

FILE: rtl/poap_if.sv
// ----------------------------------------------------------------------------
// poap_if
// Valid/ready channels carrying query and answer requests.
// ----------------------------------------------------------------------------
`default_nettype none
interface poap_query_if;
	import poap_pkg::*;
	logic   valid;
	logic   ready;
	query_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface poap_answer_if;
	import poap_pkg::*;
	logic    valid;
	logic    ready;
	answer_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/poap_prod.sv
// ----------------------------------------------------------------------------
// poap_prod
// Per-axis lane front end: offset from origin and offset times axis.
// ----------------------------------------------------------------------------
`default_nettype none
module poap_prod (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic signed [poap_pkg::COORD_W-1:0]   point,
	input  wire logic signed [poap_pkg::COORD_W-1:0]   origin,
	input  wire logic signed [poap_pkg::AXIS_W-1:0]    axis,
	output logic signed      [poap_pkg::PROD_W-1:0]    prod_s2,
	output logic signed      [poap_pkg::COORD_W-1:0]   point_s2,
	output logic signed      [poap_pkg::COORD_W-1:0]   origin_s2,
	output logic signed      [poap_pkg::AXIS_W-1:0]    axis_s2
);
	import poap_pkg::*;

	logic signed [DIFF_W-1:0]  diff_s1;
	logic signed [COORD_W-1:0] point_s1;
	logic signed [COORD_W-1:0] origin_s1;
	logic signed [AXIS_W-1:0]  axis_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1   <= DIFF_W'(point) - DIFF_W'(origin);
			point_s1  <= point;
			origin_s1 <= origin;
			axis_s1   <= axis;
			prod_s2   <= diff_s1 * axis_s1;
			point_s2  <= point_s1;
			origin_s2 <= origin_s1;
			axis_s2   <= axis_s1;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/poap_div.sv
// ----------------------------------------------------------------------------
// poap_div
// Per-axis lane back end: dot times axis, pipelined restoring divide by the
// squared length, sign fix-up and add to origin (the point itself on zero length).
// ----------------------------------------------------------------------------
`default_nettype none
module poap_div (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic signed [poap_pkg::DOT_W-1:0]    dot,
	input  wire logic signed [poap_pkg::AXIS_W-1:0]   axis,
	input  wire logic signed [poap_pkg::COORD_W-1:0]  point,
	input  wire logic signed [poap_pkg::COORD_W-1:0]  origin,
	input  wire logic        [poap_pkg::LEN_W-1:0]    len,
	input  wire logic                                 zero,
	output poap_pkg::lane_out_t                       lane_out
);
	import poap_pkg::*;

	logic signed [NUM_W-1:0]   num_s4;
	logic signed [COORD_W-1:0] point_s4;
	logic signed [COORD_W-1:0] origin_s4;
	logic        [LEN_W-1:0]   len_s4;
	logic                      zero_s4;
	logic        [NUM_W-1:0]   abs_s4;

	logic        [LEN_W-1:0]   rem_s5    [DIV_STAGES];
	logic        [MAG_W-1:0]   wrk_s5    [DIV_STAGES];
	logic        [LEN_W-1:0]   len_s5    [DIV_STAGES];
	logic                      neg_s5    [DIV_STAGES];
	logic                      zero_s5   [DIV_STAGES];
	logic signed [COORD_W-1:0] point_s5  [DIV_STAGES];
	logic signed [COORD_W-1:0] origin_s5 [DIV_STAGES];

	logic [LEN_W-1:0] q32;
	logic [LEN_W-1:0] qs;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4    <= dot * axis;
			point_s4  <= point;
			origin_s4 <= origin;
			len_s4    <= len;
			zero_s4   <= zero;
		end
	end

	assign abs_s4 = num_s4[NUM_W-1] ? NUM_W'(-num_s4) : NUM_W'(num_s4);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [LEN_W-1:0]          rem_in;
		logic [MAG_W-1:0]          wrk_in;
		logic [LEN_W-1:0]          len_in;
		logic                      neg_in;
		logic                      zero_in;
		logic signed [COORD_W-1:0] point_in;
		logic signed [COORD_W-1:0] origin_in;
		logic [LEN_W:0]            trial;
		logic                      ge;

		if (k == 0) begin : g_first
			assign rem_in    = '0;
			assign wrk_in    = abs_s4[MAG_W-1:0];
			assign len_in    = len_s4;
			assign neg_in    = num_s4[NUM_W-1];
			assign zero_in   = zero_s4;
			assign point_in  = point_s4;
			assign origin_in = origin_s4;
		end else begin : g_next
			assign rem_in    = rem_s5[k-1];
			assign wrk_in    = wrk_s5[k-1];
			assign len_in    = len_s5[k-1];
			assign neg_in    = neg_s5[k-1];
			assign zero_in   = zero_s5[k-1];
			assign point_in  = point_s5[k-1];
			assign origin_in = origin_s5[k-1];
		end

		assign trial = {rem_in, wrk_in[MAG_W-1]};
		assign ge    = trial >= {1'b0, len_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s5[k]    <= ge ? LEN_W'(trial - {1'b0, len_in}) : trial[LEN_W-1:0];
				wrk_s5[k]    <= {wrk_in[MAG_W-2:0], ge};
				len_s5[k]    <= len_in;
				neg_s5[k]    <= neg_in;
				zero_s5[k]   <= zero_in;
				point_s5[k]  <= point_in;
				origin_s5[k] <= origin_in;
			end
		end
	end

	assign q32 = wrk_s5[DIV_STAGES-1][LEN_W-1:0];
	assign qs  = neg_s5[DIV_STAGES-1] ? LEN_W'(-q32) : q32;

	always_comb begin
		lane_out.proj = !zero_s5[DIV_STAGES-1];
		if (zero_s5[DIV_STAGES-1]) begin
			lane_out.res = RES_W'(point_s5[DIV_STAGES-1]);
		end else begin
			lane_out.res = RES_W'(origin_s5[DIV_STAGES-1]) + $signed(qs);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/point_onto_axis_projection.sv
// Throughput: one query per cycle while the query side is not stalled; the 57-stage
// one-bit-per-stage divider in each of the three axis lanes is fully pipelined.
// A stalled answer is held in the output register; one more lands in a skid
// register, after which the query side stalls until the answer is taken.
// Reset (arst_n low) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// point_onto_axis_projection
// Projects a point onto the line origin + t*axis with three parallel lanes
// merged through the dot product.
// ----------------------------------------------------------------------------
`default_nettype none
module point_onto_axis_projection (
	input  wire logic     clk,
	input  wire logic     arst_n,
	poap_query_if.sink    query,
	poap_answer_if.source answer
);
	import poap_pkg::*;

	localparam int DEPTH = 4 + DIV_STAGES;

	logic en;
	logic vld_q [DEPTH];

	logic signed [PROD_W-1:0]  prod_x, prod_y, prod_z;
	logic signed [COORD_W-1:0] pnt_x, pnt_y, pnt_z;
	logic signed [COORD_W-1:0] org_x, org_y, org_z;
	logic signed [AXIS_W-1:0]  ax_x, ax_y, ax_z;

	logic        [LEN_W-1:0]   len_s1, len_s2, len_s3;
	logic signed [DOT_W-1:0]   dot_s3;
	logic signed [COORD_W-1:0] pnt_x_s3, pnt_y_s3, pnt_z_s3;
	logic signed [COORD_W-1:0] org_x_s3, org_y_s3, org_z_s3;
	logic signed [AXIS_W-1:0]  ax_x_s3, ax_y_s3, ax_z_s3;

	lane_out_t lane_x, lane_y, lane_z;
	answer_t   fresh;
	answer_t   out_q, skid_q;
	logic      out_v_q, skid_v_q;
	logic      push, pop;

	assign en          = !skid_v_q;
	assign query.ready = en;

	poap_prod u_prod_x (
		.clk(clk), .en(en), .point(query.data.point_x), .origin(query.data.origin_x),
		.axis(query.data.axis_x), .prod_s2(prod_x), .point_s2(pnt_x),
		.origin_s2(org_x), .axis_s2(ax_x)
	);
	poap_prod u_prod_y (
		.clk(clk), .en(en), .point(query.data.point_y), .origin(query.data.origin_y),
		.axis(query.data.axis_y), .prod_s2(prod_y), .point_s2(pnt_y),
		.origin_s2(org_y), .axis_s2(ax_y)
	);
	poap_prod u_prod_z (
		.clk(clk), .en(en), .point(query.data.point_z), .origin(query.data.origin_z),
		.axis(query.data.axis_z), .prod_s2(prod_z), .point_s2(pnt_z),
		.origin_s2(org_z), .axis_s2(ax_z)
	);

	// merge: dot product of the three lanes
	always_ff @(posedge clk) begin
		if (en) begin
			len_s1   <= query.data.axis_length_sq;
			len_s2   <= len_s1;
			len_s3   <= len_s2;
			dot_s3   <= DOT_W'(prod_x) + DOT_W'(prod_y) + DOT_W'(prod_z);
			pnt_x_s3 <= pnt_x;
			pnt_y_s3 <= pnt_y;
			pnt_z_s3 <= pnt_z;
			org_x_s3 <= org_x;
			org_y_s3 <= org_y;
			org_z_s3 <= org_z;
			ax_x_s3  <= ax_x;
			ax_y_s3  <= ax_y;
			ax_z_s3  <= ax_z;
		end
	end

	poap_div u_div_x (
		.clk(clk), .en(en), .dot(dot_s3), .axis(ax_x_s3), .point(pnt_x_s3),
		.origin(org_x_s3), .len(len_s3), .zero(len_s3 == '0), .lane_out(lane_x)
	);
	poap_div u_div_y (
		.clk(clk), .en(en), .dot(dot_s3), .axis(ax_y_s3), .point(pnt_y_s3),
		.origin(org_y_s3), .len(len_s3), .zero(len_s3 == '0), .lane_out(lane_y)
	);
	poap_div u_div_z (
		.clk(clk), .en(en), .dot(dot_s3), .axis(ax_z_s3), .point(pnt_z_s3),
		.origin(org_z_s3), .len(len_s3), .zero(len_s3 == '0), .lane_out(lane_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= query.valid;
			for (int k = 1; k < DEPTH; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_comb begin
		fresh.result_x  = lane_x.res;
		fresh.result_y  = lane_y.res;
		fresh.result_z  = lane_z.res;
		fresh.projected = lane_x.proj;
	end

	assign push = en && vld_q[DEPTH-1];
	assign pop  = out_v_q && answer.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) skid_v_q <= 1'b0;
		end else if (push) begin
			if (out_v_q && !pop) skid_v_q <= 1'b1;
			else out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) out_q <= skid_q;
		end else if (push) begin
			if (out_v_q && !pop) skid_q <= fresh;
			else out_q <= fresh;
		end
	end

	assign answer.valid = out_v_q;
	assign answer.data  = out_q;
endmodule
`default_nettype wire

FILE: rtl/poap_checker.sv
// ----------------------------------------------------------------------------
// poap_checker
// Port-level checks of the query/answer flow control.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module poap_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              q_valid,
	input wire logic              q_ready,
	input wire logic              a_valid,
	input wire logic              a_ready,
	input wire poap_pkg::answer_t a_data
);
	`ASSERT_NEXT(a_hold, clk, arst_n, a_valid && !a_ready, a_valid && $stable(a_data))
	`ASSERT_IMPL(stall_needs_answer, clk, arst_n, !q_ready, a_valid)
	`ASSERT_IMPL(stall_cause, clk, arst_n, $fell(q_ready), $past(a_valid && !a_ready))
	`ASSERT_NEXT(stall_release, clk, arst_n, !q_ready && a_ready, q_ready)
endmodule

bind point_onto_axis_projection poap_checker u_poap_checker (
	.clk(clk), .arst_n(arst_n), .q_valid(query.valid), .q_ready(query.ready),
	.a_valid(answer.valid), .a_ready(answer.ready), .a_data(answer.data)
);
`default_nettype wire

FILE: test/tb_point_onto_axis_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_onto_axis_projection
// Drives projection requests through the valid/ready query channel and checks
// every answer, field by field, against an in-order prediction built from the
// same request. Directed corner and zero-length requests come first, then random
// requests under changing idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_point_onto_axis_projection;
	import poap_pkg::*;

	localparam int LATENCY     = 62;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;

	poap_query_if  query_ch();
	poap_answer_if answer_ch();

	point_onto_axis_projection u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_ch),
		.answer (answer_ch)
	);

	answer_t answers_due[$];
	int      send_idle_pct;
	int      recv_idle_pct;
	int      cycle_count;
	bit      failed;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic answer_t project_point(query_t q);
		answer_t a;
		longint dx, dy, dz, dot, len2;
		if (q.axis_length_sq == '0) begin
			a.result_x  = RES_W'(longint'(q.point_x));
			a.result_y  = RES_W'(longint'(q.point_y));
			a.result_z  = RES_W'(longint'(q.point_z));
			a.projected = 1'b0;
			return a;
		end
		len2 = longint'({32'b0, q.axis_length_sq});
		dx   = longint'(q.point_x) - longint'(q.origin_x);
		dy   = longint'(q.point_y) - longint'(q.origin_y);
		dz   = longint'(q.point_z) - longint'(q.origin_z);
		dot  = dx * longint'(q.axis_x) + dy * longint'(q.axis_y) + dz * longint'(q.axis_z);
		a.result_x  = RES_W'(longint'(q.origin_x) + (dot * longint'(q.axis_x)) / len2);
		a.result_y  = RES_W'(longint'(q.origin_y) + (dot * longint'(q.axis_y)) / len2);
		a.result_z  = RES_W'(longint'(q.origin_z) + (dot * longint'(q.axis_z)) / len2);
		a.projected = 1'b1;
		return a;
	endfunction

	// request monitor and answer checker
	always @(posedge clk) begin
		answer_t exp_a;
		answer_t got;
		if (arst_n) begin
			if (query_ch.valid && query_ch.ready)
				answers_due.push_back(project_point(query_ch.data));
			if (answer_ch.valid && answer_ch.ready) begin
				got = answer_ch.data;
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected answer %h", $time, got);
					failed = 1'b1;
				end else begin
					exp_a = answers_due.pop_front();
					if (got.result_x !== exp_a.result_x) begin
						$display("%0t: result_x expected %h got %h", $time,
							exp_a.result_x, got.result_x);
						failed = 1'b1;
					end
					if (got.result_y !== exp_a.result_y) begin
						$display("%0t: result_y expected %h got %h", $time,
							exp_a.result_y, got.result_y);
						failed = 1'b1;
					end
					if (got.result_z !== exp_a.result_z) begin
						$display("%0t: result_z expected %h got %h", $time,
							exp_a.result_z, got.result_z);
						failed = 1'b1;
					end
					if (got.projected !== exp_a.projected) begin
						$display("%0t: projected expected %b got %b", $time,
							exp_a.projected, got.projected);
						failed = 1'b1;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		answer_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(query_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			query_ch.valid = 1'b0;
			@(negedge clk);
		end
		query_ch.valid = 1'b1;
		query_ch.data  = q;
		do
			@(posedge clk);
		while (!query_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		query_ch.valid = 1'b0;
		while (answers_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic query_t make_query(int px, int py, int pz, int ox, int oy, int oz,
			int ax, int ay, int az, bit [31:0] len2);
		query_t q;
		q.point_x  = px[23:0];
		q.point_y  = py[23:0];
		q.point_z  = pz[23:0];
		q.origin_x = ox[23:0];
		q.origin_y = oy[23:0];
		q.origin_z = oz[23:0];
		q.axis_x   = ax[15:0];
		q.axis_y   = ay[15:0];
		q.axis_z   = az[15:0];
		q.axis_length_sq = len2;
		return q;
	endfunction

	function automatic query_t random_query();
		query_t q;
		int unsigned sel;
		longint      l2;
		q   = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		sel = $urandom_range(9);
		if (sel < 3) begin
			// small geometry so that the projection lands near the line
			q.point_x  = 24'($signed($urandom_range(2000)) - 1000);
			q.point_y  = 24'($signed($urandom_range(2000)) - 1000);
			q.point_z  = 24'($signed($urandom_range(2000)) - 1000);
			q.origin_x = 24'($signed($urandom_range(200)) - 100);
			q.origin_y = 24'($signed($urandom_range(200)) - 100);
			q.origin_z = 24'($signed($urandom_range(200)) - 100);
			q.axis_x   = 16'($signed($urandom_range(64)) - 32);
			q.axis_y   = 16'($signed($urandom_range(64)) - 32);
			q.axis_z   = 16'($signed($urandom_range(64)) - 32);
		end
		case (sel)
			0, 1, 2, 3: begin
				l2 = longint'(q.axis_x) * q.axis_x + longint'(q.axis_y) * q.axis_y
					+ longint'(q.axis_z) * q.axis_z;
				q.axis_length_sq = l2[31:0];
			end
			4:       q.axis_length_sq = '0;
			5:       q.axis_length_sq = 32'($urandom_range(15));
			6:       q.axis_length_sq = 32'hFFFF_FFFF - 32'($urandom_range(3));
			default: q.axis_length_sq = $urandom;
		endcase
		return q;
	endfunction

	task automatic test_corner_requests();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_request(make_query(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
			-32768, -32768, -32768, 32'd1));
		send_request(make_query(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
			-32768, -32768, -32768, 32'd1));
		send_request(make_query(8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
			32767, -32768, 32767, 32'd1));
		send_request(make_query(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
			32767, 32767, 32767, 32'hFFFF_FFFF));
		send_request(make_query(-8388608, 8388607, 0, 8388607, -8388608, 0,
			-32768, 32767, 0, 32'hC000_0000));
		send_request(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd1));
		send_request(make_query(5, 7, -9, 1, 2, 3, 0, 0, 0, 32'd17));
		// truncation toward zero on both signs
		send_request(make_query(7, 0, 0, 0, 0, 0, 1, 0, 0, 32'd2));
		send_request(make_query(-7, 0, 0, 0, 0, 0, 1, 0, 0, 32'd2));
		send_request(make_query(3, -4, 5, 1, 1, 1, 1, -1, 1, 32'd3));
		send_request(make_query(10, 20, 30, 0, 0, 0, 3, 4, 0, 32'd25));
		send_request(make_query(-100, 50, 25, 10, -10, 5, -2, 1, 2, 32'd9));
	endtask

	task automatic test_zero_length();
		send_request(make_query(-8388608, 8388607, -1, 3, 4, 5, 1, 1, 1, 32'd0));
		send_request(make_query(8388607, -8388608, 0, -8388608, 8388607, 0,
			-32768, 32767, -1, 32'd0));
		send_request(make_query(1, -1, 123456, 0, 0, 0, 0, 0, 0, 32'd0));
	endtask

	task automatic test_random_requests(int n, int s_pct, int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (n)
			send_request(random_query());
	endtask

	task automatic test_pause_until_drained();
		send_idle_pct = 0;
		recv_idle_pct = 30;
		repeat (20)
			send_request(random_query());
		wait_drained();
		repeat (20)
			send_request(random_query());
	endtask

	initial begin
		arst_n          = 1'b0;
		failed          = 1'b0;
		cycle_count     = 0;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		query_ch.valid  = 1'b0;
		query_ch.data   = '0;
		answer_ch.ready = 1'b0;
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_corner_requests();
		test_zero_length();
		test_random_requests(120, 14, 59);
		test_random_requests(120, 59, 14);
		test_random_requests(120, 0, 0);
		test_pause_until_drained();

		wait_drained();
		repeat (LATENCY + 20)
			@(negedge clk);
		if (!failed && answers_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/poap_pkg.sv
rtl/poap_if.sv
rtl/poap_prod.sv
rtl/poap_div.sv
rtl/point_onto_axis_projection.sv
rtl/poap_checker.sv
test/tb_point_onto_axis_projection.sv
